FILE: rtl/core/ssd_pkg.sv
// Shared types, bus constants and the segment encoder for the display driver.
package ssd_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  // Operation kinds handed from the front to the back.
  localparam logic [1:0] KIND_NOP  = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [7:0] CMD_DATA_AUTO  = 8'h44;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h8F;
  localparam logic [7:0] ADDR_BASE      = 8'hC0;
  localparam logic [7:0] POINT_BIT      = 8'h80;
  localparam logic [7:0] DASH_SEGS      = 8'h40;
  localparam logic [7:0] CHAR_DASH      = 8'h2D;
  localparam logic [7:0] CHAR_DOT       = 8'h2E;

  typedef struct packed {
    logic [1:0]      kind;
    logic [3:0][7:0] segs;
  } op_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic busy_res;
    logic frame_end;
  } result_t;

  function automatic logic [7:0] encode_digit(input logic [7:0] ch, input logic [7:0] mark);
    logic [7:0] v;
    v = 8'h00;
    if (ch == CHAR_DASH) begin
      v = DASH_SEGS;
    end else if (ch inside {[8'h30:8'h39]}) begin
      case (ch[3:0])
        4'd0: v = 8'h3F;
        4'd1: v = 8'h06;
        4'd2: v = 8'h5B;
        4'd3: v = 8'h4F;
        4'd4: v = 8'h66;
        4'd5: v = 8'h6D;
        4'd6: v = 8'h7D;
        4'd7: v = 8'h07;
        4'd8: v = 8'h7F;
        4'd9: v = 8'h6F;
        default: v = 8'h00;
      endcase
    end
    if (mark == CHAR_DOT) begin
      v = v | POINT_BIT;
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/ssd_front.sv
// Front end: accepts input items, classifies them and encodes the digits.
module ssd_front (
  input  logic             item_valid,
  output logic             item_stall,
  input  logic             command,
  input  logic [3:0]       byte_count,
  input  logic [3:0][7:0]  chars,
  input  logic [3:0][7:0]  marks,
  input  logic             q_full,
  output logic             push,
  output ssd_pkg::op_t     op
);
  import ssd_pkg::*;

  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  always_comb begin
    op = '0;
    if (command) begin
      op.kind = KIND_TICK;
    end else if (byte_count[3]) begin
      // eight or more bytes: a full frame
      op.kind = KIND_LOAD;
    end else begin
      op.kind = KIND_NOP;
    end
    for (int n = 0; n < 4; n++) begin
      op.segs[n] = encode_digit(chars[n], marks[n]);
    end
  end

endmodule

FILE: rtl/core/ssd_queue.sv
// Short queue of classified operations between front and back.
module ssd_queue #(
  parameter int DEPTH = ssd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  ssd_pkg::op_t push_op,
  output logic         full,
  output logic         q_valid,
  input  logic         pop,
  output ssd_pkg::op_t head
);
  import ssd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  op_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/ssd_back.sv
// Back end: bus sequencer, pin state and the result register.
module ssd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  ssd_pkg::op_t    head,
  output logic            pop,
  output logic            result_valid,
  input  logic            result_stall,
  output ssd_pkg::result_t res
);
  import ssd_pkg::*;

  localparam logic [1:0] PART_START = 2'd0;
  localparam logic [1:0] PART_BYTE  = 2'd1;
  localparam logic [1:0] PART_STOP  = 2'd2;
  localparam logic [2:0] TXN_FIRST  = 3'd0;
  localparam logic [2:0] TXN_LAST   = 3'd5;
  localparam logic [3:0] ACK_BIT    = 4'd8;

  logic [3:0][7:0] segs, segs_next;
  logic            busy, busy_next;
  logic            clk_pin, clk_pin_next;
  logic            dio_pin, dio_pin_next;
  logic [2:0]      txn, txn_next;
  logic [1:0]      part, part_next;
  logic [1:0]      pos, pos_next;
  logic            byte_idx, byte_idx_next;
  logic [3:0]      bit_k, bit_k_next;
  logic [1:0]      ph, ph_next;
  logic            frame_end;

  logic [1:0] digit;
  logic [7:0] data;
  logic       byte_last;

  assign pop = q_valid && (!result_valid || !result_stall);

  assign digit     = txn[1:0] - 2'd1;
  assign byte_last = (txn == TXN_FIRST) || (txn == TXN_LAST) || byte_idx;

  always_comb begin
    if (byte_idx) begin
      data = segs[digit];
    end else if (txn == TXN_FIRST) begin
      data = CMD_DATA_AUTO;
    end else if (txn == TXN_LAST) begin
      data = CMD_DISPLAY_ON;
    end else begin
      data = ADDR_BASE | {6'd0, digit};
    end
  end

  always_comb begin
    segs_next     = segs;
    busy_next     = busy;
    clk_pin_next  = clk_pin;
    dio_pin_next  = dio_pin;
    txn_next      = txn;
    part_next     = part;
    pos_next      = pos;
    byte_idx_next = byte_idx;
    bit_k_next    = bit_k;
    ph_next       = ph;
    frame_end     = 1'b0;
    if (pop && head.kind == KIND_LOAD && !busy) begin
      segs_next     = head.segs;
      busy_next     = 1'b1;
      txn_next      = TXN_FIRST;
      part_next     = PART_START;
      pos_next      = 2'd0;
      byte_idx_next = 1'b0;
      bit_k_next    = '0;
      ph_next       = '0;
    end else if (pop && head.kind == KIND_TICK && busy) begin
      case (part)
        PART_START: begin
          case (pos)
            2'd0: clk_pin_next = 1'b1;
            2'd1: dio_pin_next = 1'b1;
            2'd2: dio_pin_next = 1'b0;
            default: clk_pin_next = 1'b0;
          endcase
          pos_next = pos + 2'd1;
          if (pos == 2'd3) begin
            part_next     = PART_BYTE;
            byte_idx_next = 1'b0;
            bit_k_next    = '0;
            ph_next       = '0;
          end
        end
        PART_BYTE: begin
          case (ph)
            2'd0: begin
              clk_pin_next = 1'b0;
              ph_next      = 2'd1;
            end
            2'd1: begin
              // ack slot releases the data pin
              dio_pin_next = (bit_k == ACK_BIT) ? 1'b1 : data[bit_k[2:0]];
              ph_next      = 2'd2;
            end
            default: begin
              clk_pin_next = 1'b1;
              ph_next      = 2'd0;
              bit_k_next   = bit_k + 4'd1;
              if (bit_k == ACK_BIT) begin
                bit_k_next = '0;
                if (byte_last) begin
                  part_next = PART_STOP;
                  pos_next  = 2'd0;
                end else begin
                  byte_idx_next = 1'b1;
                end
              end
            end
          endcase
        end
        default: begin
          case (pos)
            2'd0: clk_pin_next = 1'b0;
            2'd1: dio_pin_next = 1'b0;
            2'd2: clk_pin_next = 1'b1;
            default: dio_pin_next = 1'b1;
          endcase
          pos_next = pos + 2'd1;
          if (pos == 2'd3) begin
            part_next = PART_START;
            if (txn == TXN_LAST) begin
              txn_next  = TXN_FIRST;
              busy_next = 1'b0;
              frame_end = 1'b1;
            end else begin
              txn_next = txn + 3'd1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segs     <= '0;
      busy     <= 1'b0;
      clk_pin  <= 1'b1;
      dio_pin  <= 1'b1;
      txn      <= TXN_FIRST;
      part     <= PART_START;
      pos      <= '0;
      byte_idx <= 1'b0;
      bit_k    <= '0;
      ph       <= '0;
      result_valid <= 1'b0;
    end else begin
      segs     <= segs_next;
      busy     <= busy_next;
      clk_pin  <= clk_pin_next;
      dio_pin  <= dio_pin_next;
      txn      <= txn_next;
      part     <= part_next;
      pos      <= pos_next;
      byte_idx <= byte_idx_next;
      bit_k    <= bit_k_next;
      ph       <= ph_next;
      if (pop) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Hold the result while stalled; load a new one on every pop.
  always_ff @(posedge clk) begin
    if (pop) begin
      res.clk_level <= clk_pin_next;
      res.dio_level <= dio_pin_next;
      res.busy_res  <= busy_next;
      res.frame_end <= frame_end;
    end
  end

endmodule

FILE: rtl/core/seven_segment_two_wire_display_driver.sv
// Top level: four-digit seven-segment driver for a two-wire clock/data bus.
// An item passes through the queue and then into the result register; a stall can hold it back.
// Throughput: one item per cycle unless stalled, set by the single-step back-end bus sequencer.
// A frame takes 318 tick items after its load; loads and ticks share the one input channel.
// Reset (synchronous, active high) empties the queue and result register, clears digits,
// leaves the bus idle with both pins high and not busy.
module seven_segment_two_wire_display_driver #(
  parameter int QUEUE_DEPTH = ssd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       command,
  input  logic [3:0] byte_count,
  input  logic [7:0] pos0_char,
  input  logic [7:0] pos0_mark,
  input  logic [7:0] pos1_char,
  input  logic [7:0] pos1_mark,
  input  logic [7:0] pos2_char,
  input  logic [7:0] pos2_mark,
  input  logic [7:0] pos3_char,
  input  logic [7:0] pos3_mark,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       clk_level,
  output logic       dio_level,
  output logic       busy_res,
  output logic       frame_end
);
  import ssd_pkg::*;

  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            pop;
  op_t             push_op;
  op_t             head;
  result_t         res;
  logic [3:0][7:0] chars;
  logic [3:0][7:0] marks;

  assign chars = {pos3_char, pos2_char, pos1_char, pos0_char};
  assign marks = {pos3_mark, pos2_mark, pos1_mark, pos0_mark};

  ssd_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .byte_count (byte_count),
    .chars      (chars),
    .marks      (marks),
    .q_full     (q_full),
    .push       (push),
    .op         (push_op)
  );

  ssd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .q_valid (q_valid),
    .pop     (pop),
    .head    (head)
  );

  ssd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .res          (res)
  );

  assign clk_level = res.clk_level;
  assign dio_level = res.dio_level;
  assign busy_res  = res.busy_res;
  assign frame_end = res.frame_end;

  // The last write of a frame clears busy in the same result.
  a_end_not_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_end |-> !busy_res)
    else $error("frame end reported while still busy");

  // Between frames the bus rests with both pins high.
  a_idle_pins_high: assert property (@(posedge clk) disable iff (rst)
    result_valid && !busy_res |-> clk_level && dio_level)
    else $error("bus not idle high outside a frame");

  // An entry that is not popped stays in the queue.
  a_queue_holds: assert property (@(posedge clk) disable iff (rst)
    q_valid && !pop |=> q_valid)
    else $error("queue entry lost");

endmodule

FILE: tb/sv/tb.sv
// Self-checking regression for the four-digit two-wire display driver.
module tb;
  import ssd_pkg::*;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam logic PIN_DIO = 1'b0;
  localparam logic PIN_CLK = 1'b1;
  localparam int CMD_TXN_STEPS = 35;
  localparam int DIGIT_TXN_STEPS = 62;
  localparam int FRAME_STEPS = 2 * CMD_TXN_STEPS + 4 * DIGIT_TXN_STEPS;
  localparam int ITEM_TARGET = 1950;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic       cmd;
    logic [3:0] count;
    logic [7:0] chr[4];
    logic [7:0] mrk[4];
  } bus_item_t;

  class display_bus_scoreboard;
    logic [7:0] digit_seg[4];
    int         step;
    logic       clk_pin;
    logic       dio_pin;
    logic       busy;
    result_t    expected_pins[$];
    int         errors;

    function new();
      foreach (digit_seg[i]) digit_seg[i] = 8'h00;
      step = 0;
      clk_pin = 1'b1;
      dio_pin = 1'b1;
      busy = 1'b0;
      errors = 0;
    endfunction

    function logic [7:0] seg_code(logic [7:0] ch, logic [7:0] mk);
      logic [7:0] code;
      case (ch)
        "0": code = 8'h3F;
        "1": code = 8'h06;
        "2": code = 8'h5B;
        "3": code = 8'h4F;
        "4": code = 8'h66;
        "5": code = 8'h6D;
        "6": code = 8'h7D;
        "7": code = 8'h07;
        "8": code = 8'h7F;
        "9": code = 8'h6F;
        CHAR_DASH: code = DASH_SEGS;
        default: code = 8'h00;
      endcase
      if (mk == CHAR_DOT) code = code | POINT_BIT;
      return code;
    endfunction

    // Returns {pin, level} for offset o inside a start/bytes/stop transaction.
    function logic [1:0] txn_pin(int o, int nbytes, logic [7:0] b0, logic [7:0] b1);
      logic [7:0] data;
      int r;
      int k;
      if (o < 4) begin
        case (o)
          0: return {PIN_CLK, 1'b1};
          1: return {PIN_DIO, 1'b1};
          2: return {PIN_DIO, 1'b0};
          default: return {PIN_CLK, 1'b0};
        endcase
      end
      o = o - 4;
      if (o < 27 * nbytes) begin
        data = (o < 27) ? b0 : b1;
        r = o % 27;
        k = r / 3;
        case (r % 3)
          0: return {PIN_CLK, 1'b0};
          1: return {PIN_DIO, (k < 8) ? data[k] : 1'b1};
          default: return {PIN_CLK, 1'b1};
        endcase
      end
      case (o - 27 * nbytes)
        0: return {PIN_CLK, 1'b0};
        1: return {PIN_DIO, 1'b0};
        2: return {PIN_CLK, 1'b1};
        default: return {PIN_DIO, 1'b1};
      endcase
    endfunction

    function logic [1:0] frame_pin(int t);
      int u;
      int d;
      if (t < CMD_TXN_STEPS) return txn_pin(t, 1, CMD_DATA_AUTO, 8'h00);
      u = t - CMD_TXN_STEPS;
      if (u < 4 * DIGIT_TXN_STEPS) begin
        d = u / DIGIT_TXN_STEPS;
        return txn_pin(u % DIGIT_TXN_STEPS, 2, ADDR_BASE + 8'(d), digit_seg[d]);
      end
      return txn_pin(u - 4 * DIGIT_TXN_STEPS, 1, CMD_DISPLAY_ON, 8'h00);
    endfunction

    function void note_item(bus_item_t it);
      logic [1:0] wr;
      logic       fin;
      fin = 1'b0;
      if (it.cmd == CMD_LOAD) begin
        if (!busy && it.count >= 4'd8) begin
          foreach (digit_seg[n]) digit_seg[n] = seg_code(it.chr[n], it.mrk[n]);
          step = 0;
          busy = 1'b1;
        end
      end else if (busy) begin
        wr = frame_pin(step);
        if (wr[1] == PIN_CLK) clk_pin = wr[0];
        else dio_pin = wr[0];
        step++;
        if (step >= FRAME_STEPS) begin
          step = 0;
          busy = 1'b0;
          fin = 1'b1;
        end
      end
      expected_pins.push_back('{clk_pin, dio_pin, busy, fin});
    endfunction

    function void check_pins(result_t got);
      result_t want;
      string   field_name[4];
      field_name = '{"frame_end", "busy_res", "dio_level", "clk_level"};
      if (expected_pins.size() == 0) begin
        $display("%0t unexpected result: expected none actual %b", $time, got);
        errors++;
        return;
      end
      want = expected_pins.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (want[i] !== got[i]) begin
          $display("%0t %s mismatch: expected %b actual %b", $time, field_name[i],
                   want[i], got[i]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  logic       command;
  logic [3:0] byte_count;
  logic [7:0] pos0_char, pos0_mark, pos1_char, pos1_mark;
  logic [7:0] pos2_char, pos2_mark, pos3_char, pos3_mark;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       clk_level;
  logic       dio_level;
  logic       busy_res;
  logic       frame_end;

  display_bus_scoreboard sb = new();
  int burst_left = 0;
  int sent = 0;
  int cycles = 0;
  int stall_kind = 0;
  int stall_left = 0;

  seven_segment_two_wire_display_driver uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .command(command),
    .byte_count(byte_count),
    .pos0_char(pos0_char),
    .pos0_mark(pos0_mark),
    .pos1_char(pos1_char),
    .pos1_mark(pos1_mark),
    .pos2_char(pos2_char),
    .pos2_mark(pos2_mark),
    .pos3_char(pos3_char),
    .pos3_mark(pos3_mark),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .clk_level(clk_level),
    .dio_level(dio_level),
    .busy_res(busy_res),
    .frame_end(frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("seven_segment_two_wire_display_driver regression: fail");
      $finish;
    end
  end

  // Receiver: free runs, random stalls and short solid stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 2);
      stall_left = (stall_kind == 2) ? $urandom_range(1, 6) : $urandom_range(1, 60);
    end
    stall_left--;
    if (stall_kind == 1) result_stall <= 1'($urandom_range(0, 1));
    else result_stall <= (stall_kind == 2);
  end

  always @(posedge clk) begin
    bus_item_t seen;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        seen.cmd = command;
        seen.count = byte_count;
        seen.chr = '{pos0_char, pos1_char, pos2_char, pos3_char};
        seen.mrk = '{pos0_mark, pos1_mark, pos2_mark, pos3_mark};
        sb.note_item(seen);
      end
      if (result_valid && !result_stall)
        sb.check_pins('{clk_level, dio_level, busy_res, frame_end});
    end
  end

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return "0" + 8'($urandom_range(0, 9));
      5: return CHAR_DASH;
      6: return CHAR_DOT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] rand_mark();
    return ($urandom_range(0, 1) == 0) ? CHAR_DOT : 8'($urandom_range(0, 255));
  endfunction

  function automatic bus_item_t load_item(logic [3:0] cnt, logic [7:0] c0, logic [7:0] m0,
                                          logic [7:0] c1, logic [7:0] m1, logic [7:0] c2,
                                          logic [7:0] m2, logic [7:0] c3, logic [7:0] m3);
    bus_item_t it;
    it.cmd = CMD_LOAD;
    it.count = cnt;
    it.chr = '{c0, c1, c2, c3};
    it.mrk = '{m0, m1, m2, m3};
    return it;
  endfunction

  function automatic bus_item_t rand_load(logic [3:0] cnt);
    return load_item(cnt, rand_char(), rand_mark(), rand_char(), rand_mark(),
                     rand_char(), rand_mark(), rand_char(), rand_mark());
  endfunction

  function automatic bus_item_t tick_item();
    bus_item_t it;
    it = rand_load(4'($urandom_range(0, 15)));
    it.cmd = CMD_TICK;
    return it;
  endfunction

  task automatic send_item(bus_item_t it);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    item_valid <= 1'b1;
    command <= it.cmd;
    byte_count <= it.count;
    pos0_char <= it.chr[0];
    pos0_mark <= it.mrk[0];
    pos1_char <= it.chr[1];
    pos1_mark <= it.mrk[1];
    pos2_char <= it.chr[2];
    pos2_mark <= it.mrk[2];
    pos3_char <= it.chr[3];
    pos3_mark <= it.mrk[3];
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
  endtask

  // Tick a whole frame out; noisy runs slip in loads that land while busy.
  task automatic run_frame(bit noisy);
    for (int i = 0; i < FRAME_STEPS; i++) begin
      if (noisy && $urandom_range(0, 49) == 0) send_item(rand_load(4'($urandom_range(0, 15))));
      send_item(tick_item());
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    rst = 1'b1;
    item_valid <= 1'b0;
    command <= CMD_TICK;
    byte_count <= 4'd0;
    {pos0_char, pos0_mark, pos1_char, pos1_mark} <= '0;
    {pos2_char, pos2_mark, pos3_char, pos3_mark} <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_item(tick_item());
    send_item(load_item(4'd0, "8", CHAR_DOT, "8", CHAR_DOT, "8", CHAR_DOT, "8", CHAR_DOT));
    send_item(load_item(4'd7, "8", CHAR_DOT, "8", CHAR_DOT, "8", CHAR_DOT, "8", CHAR_DOT));
    send_item(load_item(4'd15, "0", CHAR_DOT, CHAR_DASH, CHAR_DOT, 8'hFF, 8'h00, "9", 8'hFF));
    send_item(load_item(4'd8, "1", CHAR_DOT, "1", CHAR_DOT, "1", CHAR_DOT, "1", CHAR_DOT));
    run_frame(1'b0);
    send_item(tick_item());
    send_item(load_item(4'd8, "/", CHAR_DASH, ":", CHAR_DOT, 8'h00, CHAR_DOT, "7", "/"));
    run_frame(1'b0);

    // Hold the sender until the block has caught up completely.
    item_valid <= 1'b0;
    burst_left = 0;
    wait_drained();

    // Stop about half a frame early so the last frame lands near the target.
    while (sent + FRAME_STEPS / 2 < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(rand_load(4'($urandom_range(0, 7))));
        repeat ($urandom_range(1, 4)) send_item(tick_item());
      end else begin
        send_item(rand_load(4'($urandom_range(8, 15))));
        run_frame(1'b1);
        if ($urandom_range(0, 3) == 0) send_item(tick_item());
      end
    end

    item_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("seven_segment_two_wire_display_driver regression: pass");
    else
      $display("seven_segment_two_wire_display_driver regression: fail");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/ssd_pkg.sv
rtl/core/ssd_front.sv
rtl/core/ssd_queue.sv
rtl/core/ssd_back.sv
rtl/core/seven_segment_two_wire_display_driver.sv
tb/sv/tb.sv
